### hdl/frq_pkg.sv
// frq_pkg: shared types, codes and constants of the frame ring queue
// no dependencies; used by frame_ring_queue, frq_out_buf, frq_ctrl and the testbench
`timescale 1ns / 1ps

package frq_pkg;

	// default geometry, handed down as top-level parameters
	localparam int SLOTS_DEF      = 16;
	localparam int SLOT_BYTES_DEF = 64;

	// fixed field widths
	localparam int DATA_W      = 8;
	localparam int LEN_W       = 7;
	localparam int OCC_W       = 5;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 24;
	localparam int OUT_USER_W  = 3;

	// request kinds carried in the low tuser bit
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED    = 3'd0,
		ST_DROP_FULL   = 3'd1,
		ST_DROP_LONG   = 3'd2,
		ST_BYTE        = 3'd3,
		ST_EMPTY_FRAME = 3'd4,
		ST_QUEUE_EMPTY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		DROP_NONE = 2'd0,
		DROP_FULL = 2'd1,
		DROP_LONG = 2'd2
	} drop_t;

	typedef enum logic [1:0] {
		CT_IDLE  = 2'd0,
		CT_LEN   = 2'd1,
		CT_BYTES = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   byte_out;
		logic [LEN_W-1:0]    frame_length;
		logic                last;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	// free space in the output queue after this cycle's departure
	typedef struct packed {
		logic room_one;
		logic room_two;
	} buf_room_t;

	function automatic status_t drop_status(input drop_t d);
		status_t s;
		unique case (d)
			DROP_NONE: s = ST_ACCEPTED;
			DROP_FULL: s = ST_DROP_FULL;
			DROP_LONG: s = ST_DROP_LONG;
			default:   s = ST_ACCEPTED;
		endcase
		return s;
	endfunction

endpackage

### hdl/frame_ring_queue.sv
// frame_ring_queue: top level of the frame ring queue, stream ports on both sides
// depends on frq_pkg, frq_ram, frq_out_buf and frq_ctrl
`timescale 1ns / 1ps

// frame queue of SLOTS slots, each up to SLOT_BYTES bytes with a stored length.
// a push request (tuser bit 0 low) carries one frame byte when tuser bit 1 is
// set; the request with tlast set closes the frame and returns one status
// result (accepted, dropped full, dropped too long). a pop request returns the
// oldest frame one byte per result with tlast on the final byte, one empty
// frame result for a zero-length frame, or one queue empty result.
// push requests are taken back to back while the controller is idle and the
// result queue has room. a pop holds the input from the accepting cycle,
// which issues the length ram read, through the length state and the byte
// ram reads, one per cycle while the result queue has room, until the final
// byte leaves the byte ram read register. an empty frame pop ends in the
// length state, an empty queue pop in the accepting cycle. the byte ram's
// single read port sets the pop rate. results pass through a two-entry queue,
// so a stalled master side stalls byte reads and, once full, the slave side.
// both rams start undefined; only written entries are ever read.

module frame_ring_queue #(
	parameter int SLOTS      = frq_pkg::SLOTS_DEF,
	parameter int SLOT_BYTES = frq_pkg::SLOT_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [frq_pkg::DATA_W-1:0]       s_axis_tdata,  // [7:0] byte_in
	input  logic [frq_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [0] cmd, [1] has_byte
	input  logic                             s_axis_tlast,  // frame_end
	// result side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] byte_out, [14:8] frame_length, [19:15] occupancy, [23:20] zero
	output logic [frq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [frq_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [2:0] status
	output logic                             m_axis_tlast   // last
);

	localparam int SW     = $clog2(SLOTS);
	localparam int BDEPTH = SLOTS * SLOT_BYTES;
	localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int PAD_W  = frq_pkg::OUT_DATA_W - frq_pkg::DATA_W - frq_pkg::LEN_W
		- frq_pkg::OCC_W;

	// ram ports
	logic                          bwe, bre;
	logic [AW-1:0]                 bwaddr, braddr;
	logic [frq_pkg::DATA_W-1:0]    bwdata, brdata;
	logic                          lwe, lre;
	logic [SW-1:0]                 lwaddr, lraddr;
	logic [frq_pkg::LEN_W-1:0]     lwdata, lrdata;

	// controller to result queue
	logic                 enq;
	frq_pkg::result_t     enq_res;
	frq_pkg::buf_room_t   room;
	frq_pkg::result_t     out_res;

	// frame bytes, slot-major: slot * SLOT_BYTES + byte index
	frq_ram #(
		.WIDTH (frq_pkg::DATA_W),
		.DEPTH (BDEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (bwe),
		.waddr (bwaddr),
		.wdata (bwdata),
		.re    (bre),
		.raddr (braddr),
		.rdata (brdata)
	);

	// one stored length per slot, written at commit
	frq_ram #(
		.WIDTH (frq_pkg::LEN_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (lre),
		.raddr (lraddr),
		.rdata (lrdata)
	);

	frq_ctrl #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_cmd       (s_axis_tuser[0]),
		.in_byte      (s_axis_tdata),
		.in_has_byte  (s_axis_tuser[1]),
		.in_frame_end (s_axis_tlast),
		.room         (room),
		.enq          (enq),
		.enq_res      (enq_res),
		.bwe          (bwe),
		.bwaddr       (bwaddr),
		.bwdata       (bwdata),
		.bre          (bre),
		.braddr       (braddr),
		.brdata       (brdata),
		.lwe          (lwe),
		.lwaddr       (lwaddr),
		.lwdata       (lwdata),
		.lre          (lre),
		.lraddr       (lraddr),
		.lrdata       (lrdata)
	);

	// decouples result requests from master-side backpressure
	frq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_res   (enq_res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// result packing
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.occupancy, out_res.frame_length,
		out_res.byte_out};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

endmodule

### hdl/frq_ram.sv
// frq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module frq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/frq_out_buf.sv
// frq_out_buf: two-entry result queue in front of the master stream port
// depends on frq_pkg
`timescale 1ns / 1ps

module frq_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enq,
	input  frq_pkg::result_t    enq_res,
	output frq_pkg::buf_room_t  room,
	output logic                out_valid,
	input  logic                out_ready,
	output frq_pkg::result_t    out_res
);

	frq_pkg::result_t ent_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       pop;
	logic [1:0] count_eff;

	assign out_valid = (count_q != 2'd0);
	assign out_res   = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count_eff = count_q - {1'b0, pop};

	assign room.room_one = (count_eff <= 2'd1);
	assign room.room_two = (count_eff == 2'd0);

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wr_ptr_q] <= enq_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			count_q <= count_eff + {1'b0, enq};
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		enq && (count_q == 2'd2) |-> pop)
		else $error("result queued into a full queue");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q == rd_ptr_q) == ((count_q == 2'd0) || (count_q == 2'd2)))
		else $error("result queue pointers disagree with count");
`endif

endmodule

### hdl/frq_ctrl.sv
// frq_ctrl: push collection, commit, pop sequencing and slot pointers
// depends on frq_pkg; drives the byte and length rams and the result queue
`timescale 1ns / 1ps

module frq_ctrl #(
	parameter int SLOTS      = frq_pkg::SLOTS_DEF,
	parameter int SLOT_BYTES = frq_pkg::SLOT_BYTES_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1),
	localparam int BDEPTH = SLOTS * SLOT_BYTES,
	localparam int AW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_cmd,
	input  logic [frq_pkg::DATA_W-1:0]    in_byte,
	input  logic                          in_has_byte,
	input  logic                          in_frame_end,
	input  frq_pkg::buf_room_t            room,
	output logic                          enq,
	output frq_pkg::result_t              enq_res,
	output logic                          bwe,
	output logic [AW-1:0]                 bwaddr,
	output logic [frq_pkg::DATA_W-1:0]    bwdata,
	output logic                          bre,
	output logic [AW-1:0]                 braddr,
	input  logic [frq_pkg::DATA_W-1:0]    brdata,
	output logic                          lwe,
	output logic [SW-1:0]                 lwaddr,
	output logic [frq_pkg::LEN_W-1:0]     lwdata,
	output logic                          lre,
	output logic [SW-1:0]                 lraddr,
	input  logic [frq_pkg::LEN_W-1:0]     lrdata
);

	localparam logic [SW-1:0]               LAST_SLOT = SW'(SLOTS - 1);
	localparam logic [CW-1:0]               FULL_CNT  = CW'(SLOTS);
	localparam logic [frq_pkg::LEN_W-1:0]   MAX_LEN   = frq_pkg::LEN_W'(SLOT_BYTES);

	frq_pkg::ctrl_state_t state_q, state_d;

	logic [SW-1:0]              wr_slot_q, wr_slot_d;
	logic [SW-1:0]              rd_slot_q, rd_slot_d;
	logic [SW-1:0]              pop_slot_q, pop_slot_d;
	logic [CW-1:0]              count_q, count_d;
	logic [frq_pkg::LEN_W-1:0]  taken_q, taken_d;
	logic                       in_frame_q, in_frame_d;
	frq_pkg::drop_t             drop_q, drop_d;
	logic [frq_pkg::LEN_W-1:0]  len_q, len_d;
	logic [frq_pkg::LEN_W-1:0]  idx_q, idx_d;
	logic                       rd_v_s1, rd_v_d;
	logic                       last_s1, last_d;

	logic                       accept;
	logic                       direct_enq;
	logic                       issue;
	logic                       idx_last;
	frq_pkg::drop_t             cur_drop, new_drop;
	logic [frq_pkg::LEN_W-1:0]  cur_taken, new_taken;
	logic                       store;

	assign in_ready = (state_q == frq_pkg::CT_IDLE) && !rd_v_s1 && room.room_one;
	assign accept   = in_valid && in_ready;

	// push bookkeeping: the full drop decision is taken on the first request of a frame
	always_comb begin
		cur_drop  = in_frame_q ? drop_q
			: ((count_q >= FULL_CNT) ? frq_pkg::DROP_FULL : frq_pkg::DROP_NONE);
		cur_taken = in_frame_q ? taken_q : '0;
		store     = in_has_byte && (cur_drop == frq_pkg::DROP_NONE) && (cur_taken < MAX_LEN);
		new_drop  = (in_has_byte && (cur_drop == frq_pkg::DROP_NONE) && !store)
			? frq_pkg::DROP_LONG : cur_drop;
		new_taken = store ? cur_taken + frq_pkg::LEN_W'(1) : cur_taken;
	end

	assign idx_last = ((idx_q + frq_pkg::LEN_W'(1)) == len_q);
	assign issue    = (state_q == frq_pkg::CT_BYTES)
		&& (rd_v_s1 ? room.room_two : room.room_one);

	always_comb begin
		state_d    = state_q;
		wr_slot_d  = wr_slot_q;
		rd_slot_d  = rd_slot_q;
		pop_slot_d = pop_slot_q;
		count_d    = count_q;
		taken_d    = taken_q;
		in_frame_d = in_frame_q;
		drop_d     = drop_q;
		len_d      = len_q;
		idx_d      = idx_q;
		rd_v_d     = 1'b0;
		last_d     = last_s1;

		direct_enq = 1'b0;
		enq_res    = '0;

		bwe    = 1'b0;
		bwaddr = AW'(wr_slot_q) * AW'(SLOT_BYTES) + AW'(cur_taken);
		bwdata = in_byte;
		bre    = 1'b0;
		braddr = AW'(pop_slot_q) * AW'(SLOT_BYTES) + AW'(idx_q);
		lwe    = 1'b0;
		lwaddr = wr_slot_q;
		lwdata = new_taken;
		lre    = 1'b0;
		lraddr = rd_slot_q;

		unique case (state_q)
			frq_pkg::CT_IDLE: begin
				if (accept && (in_cmd == frq_pkg::CMD_PUSH)) begin
					bwe = store;
					if (in_frame_end) begin
						if (new_drop == frq_pkg::DROP_NONE) begin
							lwe       = 1'b1;
							wr_slot_d = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + SW'(1);
							count_d   = count_q + CW'(1);
						end
						direct_enq          = 1'b1;
						enq_res.status      = frq_pkg::drop_status(new_drop);
						enq_res.frame_length = (new_drop == frq_pkg::DROP_NONE) ? new_taken : '0;
						enq_res.last        = 1'b1;
						enq_res.occupancy   = frq_pkg::OCC_W'(count_d);
						in_frame_d = 1'b0;
						taken_d    = '0;
						drop_d     = frq_pkg::DROP_NONE;
					end else begin
						in_frame_d = 1'b1;
						taken_d    = new_taken;
						drop_d     = new_drop;
					end
				end else if (accept) begin
					if (count_q == '0) begin
						direct_enq     = 1'b1;
						enq_res.status = frq_pkg::ST_QUEUE_EMPTY;
						enq_res.last   = 1'b1;
					end else begin
						lre        = 1'b1;
						pop_slot_d = rd_slot_q;
						rd_slot_d  = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + SW'(1);
						count_d    = count_q - CW'(1);
						state_d    = frq_pkg::CT_LEN;
					end
				end
			end
			frq_pkg::CT_LEN: begin
				if (lrdata == '0) begin
					direct_enq        = 1'b1;
					enq_res.status    = frq_pkg::ST_EMPTY_FRAME;
					enq_res.last      = 1'b1;
					enq_res.occupancy = frq_pkg::OCC_W'(count_q);
					state_d           = frq_pkg::CT_IDLE;
				end else begin
					len_d   = lrdata;
					idx_d   = '0;
					state_d = frq_pkg::CT_BYTES;
				end
			end
			frq_pkg::CT_BYTES: begin
				if (issue) begin
					bre    = 1'b1;
					rd_v_d = 1'b1;
					last_d = idx_last;
					idx_d  = idx_q + frq_pkg::LEN_W'(1);
					if (idx_last) begin
						state_d = frq_pkg::CT_IDLE;
					end
				end
			end
			default: begin
				state_d = frq_pkg::CT_IDLE;
			end
		endcase

		// a byte read issued last cycle lands in the result queue now
		if (rd_v_s1) begin
			enq_res.status       = frq_pkg::ST_BYTE;
			enq_res.byte_out     = brdata;
			enq_res.frame_length = len_q;
			enq_res.last         = last_s1;
			enq_res.occupancy    = frq_pkg::OCC_W'(count_q);
		end
	end

	assign enq = direct_enq || rd_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frq_pkg::CT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			count_q    <= '0;
			taken_q    <= '0;
			in_frame_q <= 1'b0;
			drop_q     <= frq_pkg::DROP_NONE;
			rd_v_s1    <= 1'b0;
		end else begin
			wr_slot_q  <= wr_slot_d;
			rd_slot_q  <= rd_slot_d;
			count_q    <= count_d;
			taken_q    <= taken_d;
			in_frame_q <= in_frame_d;
			drop_q     <= drop_d;
			rd_v_s1    <= rd_v_d;
		end
	end

	always_ff @(posedge clk) begin
		pop_slot_q <= pop_slot_d;
		len_q      <= len_d;
		idx_q      <= idx_d;
		last_s1    <= last_d;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored frame count above slot count");

	a_enq_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(direct_enq && rd_v_s1))
		else $error("two results queued in one cycle");

	a_len_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frq_pkg::CT_LEN) |-> $past(lre))
		else $error("length state entered without a length read");

	a_closed_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (taken_q == '0) && (drop_q == frq_pkg::DROP_NONE))
		else $error("push state left over after frame close");
`endif

endmodule

### test/frq_checker.sv
`timescale 1ns / 1ps
// frq_checker: watches both stream channels of frame_ring_queue, keeps a shadow of its
// frame slots, predicts every result and compares it field by field; depends on frq_pkg

module frq_checker #(
	parameter int SLOTS      = frq_pkg::SLOTS_DEF,
	parameter int SLOT_BYTES = frq_pkg::SLOT_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [frq_pkg::DATA_W-1:0]       s_axis_tdata,
	input  logic [frq_pkg::IN_USER_W-1:0]    s_axis_tuser,
	input  logic                             s_axis_tlast,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [frq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic [frq_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	input  logic                             m_axis_tlast,
	output int                               mismatches,
	output int                               outstanding,
	output int                               results_checked
);
	import frq_pkg::*;

	localparam int PAD_LO = DATA_W + LEN_W + OCC_W;
	localparam int BAW    = (SLOTS * SLOT_BYTES > 1) ? $clog2(SLOTS * SLOT_BYTES) : 1;
	localparam int SAW    = $clog2(SLOTS);

	// shadow of the frame slots
	logic [DATA_W-1:0] shadow_bytes [SLOTS*SLOT_BYTES];
	logic [LEN_W-1:0]  shadow_lens [SLOTS];
	int                rd_slot;
	int                wr_slot;
	int                stored;
	int                taken;
	logic              open_frame;
	drop_t             drop_cause;

	result_t           results_due [$];
	int                bad;
	int                seen;

	task automatic add_result(input status_t st, input logic [DATA_W-1:0] b,
		input logic [LEN_W-1:0] len, input logic lst);
		result_t r;
		r.status       = st;
		r.byte_out     = b;
		r.frame_length = len;
		r.last         = lst;
		r.occupancy    = OCC_W'(stored);
		results_due.push_back(r);
	endtask

	// advance the shadow by one accepted request and queue what it should produce
	task automatic track_request(input logic cmd, input logic [DATA_W-1:0] b,
		input logic has, input logic fend);
		status_t st;
		int      slot;
		int      len;
		int      i;
		if (cmd == CMD_PUSH) begin
			if (!open_frame) begin
				open_frame = 1'b1;
				taken      = 0;
				drop_cause = (stored >= SLOTS) ? DROP_FULL : DROP_NONE;
			end
			if (has && drop_cause == DROP_NONE) begin
				if (taken < SLOT_BYTES) begin
					shadow_bytes[BAW'(wr_slot*SLOT_BYTES + taken)] = b;
					taken++;
				end else begin
					drop_cause = DROP_LONG;
				end
			end
			if (fend) begin
				len = 0;
				case (drop_cause)
					DROP_FULL: st = ST_DROP_FULL;
					DROP_LONG: st = ST_DROP_LONG;
					default: begin
						st                  = ST_ACCEPTED;
						len                 = taken;
						shadow_lens[SAW'(wr_slot)] = LEN_W'(len);
						wr_slot             = (wr_slot + 1) % SLOTS;
						stored++;
					end
				endcase
				open_frame = 1'b0;
				taken      = 0;
				drop_cause = DROP_NONE;
				add_result(st, '0, LEN_W'(len), 1'b1);
			end
		end else if (stored == 0) begin
			add_result(ST_QUEUE_EMPTY, '0, '0, 1'b1);
		end else begin
			slot    = rd_slot;
			len     = int'(shadow_lens[SAW'(slot)]);
			rd_slot = (rd_slot + 1) % SLOTS;
			stored--;
			if (len == 0)
				add_result(ST_EMPTY_FRAME, '0, '0, 1'b1);
			else
				for (i = 0; i < len; i++)
					add_result(ST_BYTE, shadow_bytes[BAW'(slot*SLOT_BYTES + i)],
						LEN_W'(len), i == len - 1);
		end
	endtask

	task automatic check_result();
		result_t            want;
		logic [DATA_W-1:0]  got_byte;
		logic [LEN_W-1:0]   got_len;
		logic [OCC_W-1:0]   got_occ;
		logic [OUT_DATA_W-PAD_LO-1:0] got_pad;
		got_byte = m_axis_tdata[DATA_W-1:0];
		got_len  = m_axis_tdata[DATA_W +: LEN_W];
		got_occ  = m_axis_tdata[DATA_W+LEN_W +: OCC_W];
		got_pad  = m_axis_tdata[OUT_DATA_W-1:PAD_LO];
		if (results_due.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("result %0d: none expected, got status %0d byte %02h",
					seen, m_axis_tuser, got_byte,
					" len %0d occ %0d last %0b", got_len, got_occ, m_axis_tlast);
		end else begin
			want = results_due.pop_front();
			if (m_axis_tuser !== want.status || got_byte !== want.byte_out ||
				got_len !== want.frame_length || got_occ !== want.occupancy ||
				m_axis_tlast !== want.last || got_pad !== '0) begin
				bad++;
				if (bad <= 10) begin
					$display("result %0d: expected status %0d byte %02h",
						seen, want.status, want.byte_out,
						" len %0d occ %0d last %0b",
						want.frame_length, want.occupancy, want.last);
					$display("result %0d: got      status %0d byte %02h",
						seen, m_axis_tuser, got_byte,
						" len %0d occ %0d last %0b pad %h",
						got_len, got_occ, m_axis_tlast, got_pad);
				end
			end
		end
		seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot    = 0;
			wr_slot    = 0;
			stored     = 0;
			taken      = 0;
			open_frame = 1'b0;
			drop_cause = DROP_NONE;
			results_due.delete();
			bad        = 0;
			seen       = 0;
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			// requests first, so a result can never outrun its own prediction
			if (s_axis_tvalid && s_axis_tready)
				track_request(s_axis_tuser[0], s_axis_tdata[DATA_W-1:0], s_axis_tuser[1],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			mismatches      <= bad;
			outstanding     <= results_due.size();
			results_checked <= seen;
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: request stimulus and verdict for frame_ring_queue; prediction and checking
// live in frq_checker; depends on frq_pkg, frq_checker and the rtl under hdl

module tb_top;
	import frq_pkg::*;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int SLOT_BYTES   = SLOT_BYTES_DEF;
	// request budget for the whole run, directed part included
	localparam int TOTAL_ITEMS  = 300;
	// covers a full-size pop of SLOT_BYTES bytes; leave room for stray results
	localparam int TAIL_CYCLES  = SLOT_BYTES + 16;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [DATA_W-1:0]       s_axis_tdata;   // [7:0] byte_in
	logic [IN_USER_W-1:0]    s_axis_tuser;   // [0] cmd, [1] has_byte
	logic                    s_axis_tlast;   // frame_end
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;   // [7:0] byte, [14:8] length, [19:15] occupancy
	logic [OUT_USER_W-1:0]   m_axis_tuser;   // [2:0] status
	logic                    m_axis_tlast;   // last

	int   mismatches;
	int   outstanding;
	int   results_checked;
	int   requests_sent = 0;
	int   frames_sent   = 0;
	int   pops_sent     = 0;
	int   tx_run_left   = 0;
	logic tx_quiet      = 1'b0;

	frame_ring_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	frq_checker #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls before each result, with stall-free stretches
	initial begin
		int   stall;
		int   rx_run_left;
		logic rx_quiet;
		rx_run_left = 0;
		rx_quiet    = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_run_left == 0) begin
				rx_quiet    = ($urandom_range(0, 3) == 0);
				rx_run_left = $urandom_range(8, 40);
			end
			rx_run_left--;
			stall = rx_quiet ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one request, after a random gap; returns at the edge that accepts it
	task automatic send_request(input logic cmd, input logic [DATA_W-1:0] data,
		input logic has, input logic fend);
		int gap;
		if (tx_run_left == 0) begin
			tx_quiet    = ($urandom_range(0, 3) == 0);
			tx_run_left = $urandom_range(8, 40);
		end
		tx_run_left--;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= {has, cmd};
		s_axis_tlast  <= fend;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
	endtask

	// pop ignores the other fields, so they carry random values
	task automatic pop_frame();
		send_request(CMD_POP, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		pops_sent++;
	endtask

	// push a frame of nbytes random bytes; a messy frame gets byte-less filler
	// requests, pops in the middle and sometimes a byte-less closing request
	task automatic push_frame(input int nbytes, input bit messy);
		int k;
		bit tail_empty;
		tail_empty = (nbytes == 0) || (messy && $urandom_range(0, 4) == 0);
		for (k = 0; k < nbytes; k++) begin
			if (messy && $urandom_range(0, 9) == 0)
				send_request(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 1'b0, 1'b0);
			if (messy && $urandom_range(0, 29) == 0)
				pop_frame();
			send_request(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 1'b1,
				!tail_empty && k == nbytes - 1);
		end
		if (tail_empty)
			send_request(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		frames_sent++;
	endtask

	// hold the request side until every predicted result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int pop_pct;
		int r;
		int len;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on an empty queue, empty frame, extreme byte values
		pop_frame();
		push_frame(0, 1'b0);
		send_request(CMD_PUSH, 8'h00, 1'b1, 1'b0);
		send_request(CMD_PUSH, 8'hFF, 1'b1, 1'b1);
		frames_sent++;
		pop_frame();
		pop_frame();
		// pop while a push frame is open, with a byte-less request inside the frame
		send_request(CMD_PUSH, 8'hA5, 1'b1, 1'b0);
		pop_frame();
		send_request(CMD_PUSH, 8'h5A, 1'b0, 1'b0);
		send_request(CMD_PUSH, 8'h3C, 1'b1, 1'b1);
		frames_sent++;
		// largest frame that fits, then one byte too many
		push_frame(SLOT_BYTES, 1'b0);
		push_frame(SLOT_BYTES + 1, 1'b0);
		pop_frame();
		pop_frame();
		// fill every slot, then full drops, also for a frame that is too long
		repeat (SLOTS) push_frame(1, 1'b0);
		push_frame(1, 1'b0);
		push_frame(SLOT_BYTES + 1, 1'b0);
		// a frame opened while full stays dropped though a pop frees a slot
		send_request(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 1'b1, 1'b0);
		pop_frame();
		send_request(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 1'b1, 1'b1);
		frames_sent++;
		repeat (SLOTS) pop_frame();
		wait_drained();

		// random: mostly short frames, a few near or past the slot size, pop rate
		// shifting between phases so the queue both fills up and runs dry
		pop_pct = 35;
		while (requests_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				case ($urandom_range(0, 2))
					0: pop_pct = 15;
					1: pop_pct = 40;
					default: pop_pct = 70;
				endcase
			if ($urandom_range(0, 99) < pop_pct) begin
				pop_frame();
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8)
					len = 0;
				else if (r < 93)
					len = $urandom_range(1, 8);
				else if (r < 97)
					len = $urandom_range(SLOT_BYTES - 4, SLOT_BYTES);
				else
					len = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 6);
				push_frame(len, 1'b1);
			end
			if ($urandom_range(0, 49) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d requests: %0d push frames and %0d pops,",
			requests_sent, frames_sent, pops_sent);
		$display("%0d results checked against the shadow queue", results_checked);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
